// ----- rtl/gcdlr_pkg.sv -----
// ----------------------------------------------------------------------------
// gcdlr_pkg: shared types and codes for the gcd/lcm resample ratio block
// Word layouts of both channels, datapath command codes and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package gcdlr_pkg;

	localparam int OPERAND_BITS_DEF = 32;
	localparam int FIELD_BITS       = 32;
	localparam int MULT_BITS        = 64;

	typedef struct packed {
		logic [FIELD_BITS-1:0] first_value;
		logic [FIELD_BITS-1:0] second_value;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] divisor;
		logic [MULT_BITS-1:0]  multiple;
		logic [FIELD_BITS-1:0] interp_factor;
		logic [FIELD_BITS-1:0] decim_factor;
		logic                  zero_operand;
	} out_word_t;

	// Datapath operations.
	localparam logic [2:0] OP_NONE     = 3'd0;
	localparam logic [2:0] OP_LOAD     = 3'd1;
	localparam logic [2:0] OP_TWOS     = 3'd2;
	localparam logic [2:0] OP_REDUCE   = 3'd3;
	localparam logic [2:0] OP_DIV_INIT = 3'd4;
	localparam logic [2:0] OP_DIV      = 3'd5;
	localparam logic [2:0] OP_MUL      = 3'd6;

	typedef struct packed {
		logic [2:0] op;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic both_even;
		logic reduce_done;
		logic count_done;
	} status_t;

endpackage

// ----- rtl/gcdlr_dp.sv -----
// ----------------------------------------------------------------------------
// gcdlr_dp: datapath of the gcd/lcm resample ratio block
// Binary gcd registers, two restoring dividers sharing the gcd as divisor,
// one multiplier for the lcm, and the assembly of the result word.
// ----------------------------------------------------------------------------
module gcdlr_dp #(
	parameter int OPERAND_BITS = gcdlr_pkg::OPERAND_BITS_DEF
) (
	input  logic                  clk,
	input  gcdlr_pkg::in_word_t   operands,
	input  gcdlr_pkg::cmd_t       cmd,
	output gcdlr_pkg::status_t    status,
	output gcdlr_pkg::out_word_t  result
);
	import gcdlr_pkg::*;

	localparam int W   = OPERAND_BITS;
	localparam int SHW = $clog2(W);
	localparam int CW  = $clog2(W);
	localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

	logic [W-1:0]   x_q, y_q;
	logic [W-1:0]   a_q, b_q;
	logic [SHW-1:0] shift_q;
	logic [W-1:0]   g_q;
	logic [W-1:0]   qi_q, qd_q;
	logic [W-1:0]   ri_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic [2*W-1:0] prod_q;

	logic [W:0]   trial_i, trial_d;
	logic         fit_i, fit_d;
	logic [W-1:0] zero_div;

	assign trial_i = {ri_q, qi_q[W-1]};
	assign trial_d = {rd_q, qd_q[W-1]};
	assign fit_i   = trial_i >= {1'b0, g_q};
	assign fit_d   = trial_d >= {1'b0, g_q};

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q     <= operands.first_value[W-1:0];
				y_q     <= operands.second_value[W-1:0];
				a_q     <= operands.first_value[W-1:0];
				b_q     <= operands.second_value[W-1:0];
				shift_q <= '0;
			end
			OP_TWOS: begin
				a_q     <= a_q >> 1;
				b_q     <= b_q >> 1;
				shift_q <= shift_q + SHW'(1);
			end
			OP_REDUCE: begin
				if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			OP_DIV_INIT: begin
				g_q   <= (a_q | b_q) << shift_q;
				qi_q  <= y_q;
				qd_q  <= x_q;
				ri_q  <= '0;
				rd_q  <= '0;
				cnt_q <= CNT_TOP;
			end
			OP_DIV: begin
				// One quotient bit per cycle for each divider.
				ri_q  <= fit_i ? W'(trial_i - {1'b0, g_q}) : trial_i[W-1:0];
				rd_q  <= fit_d ? W'(trial_d - {1'b0, g_q}) : trial_d[W-1:0];
				qi_q  <= {qi_q[W-2:0], fit_i};
				qd_q  <= {qd_q[W-2:0], fit_d};
				cnt_q <= cnt_q - CW'(1);
			end
			OP_MUL: begin
				prod_q <= (2*W)'(qd_q) * (2*W)'(y_q);
			end
			default: begin
			end
		endcase
	end

	assign status.zero_in     = (x_q == '0) || (y_q == '0);
	assign status.both_even   = !a_q[0] && !b_q[0];
	assign status.reduce_done = (a_q == '0) || (b_q == '0);
	assign status.count_done  = (cnt_q == '0);

	assign zero_div = (x_q == '0) ? y_q : x_q;

	always_comb begin
		if (status.zero_in) begin
			result.divisor       = FIELD_BITS'(zero_div);
			result.multiple      = '0;
			result.interp_factor = '0;
			result.decim_factor  = '0;
			result.zero_operand  = 1'b1;
		end else begin
			result.divisor       = FIELD_BITS'(g_q);
			result.multiple      = MULT_BITS'(prod_q);
			result.interp_factor = FIELD_BITS'(qi_q);
			result.decim_factor  = FIELD_BITS'(qd_q);
			result.zero_operand  = 1'b0;
		end
	end

endmodule

// ----- rtl/gcdlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcdlr_ctrl: controller of the gcd/lcm resample ratio block
// Steps the datapath through load, gcd reduction, division and multiply,
// or from load to done on a zero operand, then loads the output register.
// ----------------------------------------------------------------------------
module gcdlr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operand_valid,
	output logic               operand_stall,
	input  gcdlr_pkg::status_t status,
	input  logic               slot_free,
	output gcdlr_pkg::cmd_t    cmd
);
	import gcdlr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TWOS   = 3'd1;
	localparam logic [2:0] S_REDUCE = 3'd2;
	localparam logic [2:0] S_DIVI   = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_MUL    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign operand_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (operand_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_TWOS;
				end
			end
			S_TWOS: begin
				if (status.zero_in) begin
					state_d = S_DONE;
				end else if (status.both_even) begin
					cmd.op = OP_TWOS;
				end else begin
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (status.reduce_done) begin
					state_d = S_DIVI;
				end else begin
					cmd.op = OP_REDUCE;
				end
			end
			S_DIVI: begin
				cmd.op  = OP_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (status.count_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/gcd_lcm_resample_ratio.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_resample_ratio: gcd, lcm and resampling factors of two operands
// Top level: controller, datapath and the output register.
// ----------------------------------------------------------------------------
// Each input word carries two unsigned operands, of which the low
// OPERAND_BITS bits are used. The block returns one result word per input
// word with the greatest common divisor, the least common multiple, the
// interpolation factor (second operand / gcd) and the decimation factor
// (first operand / gcd). When either operand is zero, zero_operand is set,
// the divisor is the other operand and the remaining fields are zero.
// Items are processed one at a time. An item takes a load step, binary gcd
// reduction (one shift or subtract per cycle), the two restoring dividers
// that run side by side, a multiply step and the hand-over to the output
// register; an item with a zero operand goes from the load straight to
// the hand-over.
// The finished result sits in an output register, so the next operand
// word is taken while an earlier result still waits to be read.
// ----------------------------------------------------------------------------
module gcd_lcm_resample_ratio #(
	parameter int OPERAND_BITS = gcdlr_pkg::OPERAND_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 operand_valid,
	output logic                 operand_stall,
	input  gcdlr_pkg::in_word_t  operands,
	output logic                 result_valid,
	input  logic                 result_stall,
	output gcdlr_pkg::out_word_t result
);
	import gcdlr_pkg::*;

	cmd_t      cmd;
	status_t   status;
	out_word_t dp_result;
	logic      slot_free;
	logic      result_valid_q;
	out_word_t result_q;

	// The output register can take a new result when it is empty or when
	// its current word leaves in this cycle.
	assign slot_free = !result_valid_q || !result_stall;

	gcdlr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.status        (status),
		.slot_free     (slot_free),
		.cmd           (cmd)
	);

	gcdlr_dp #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dp (
		.clk      (clk),
		.operands (operands),
		.cmd      (cmd),
		.status   (status),
		.result   (dp_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q <= dp_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Accepting an operand word always starts a busy period.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		operand_valid && !operand_stall |=> operand_stall)
		else $error("block not busy after accepting an operand word");

	// A zero operand forces the lcm and both factors to zero.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_operand |->
			result.multiple == '0 && result.interp_factor == '0 &&
			result.decim_factor == '0)
		else $error("nonzero lcm or factor on a zero operand");

	// Two nonzero operands always have a nonzero gcd.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.zero_operand |-> result.divisor != '0)
		else $error("zero gcd for nonzero operands");

	// A new result only appears after the block has been working on it.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(operand_stall))
		else $error("result word appeared without a busy period");

endmodule

// ----- tb/sv/gcdlr_ratio_checker.sv -----
// ----------------------------------------------------------------------------
// gcdlr_ratio_checker: result prediction and comparison for the ratio block
// Watches both channels, predicts the gcd, lcm and resampling factors of each
// accepted operand word and compares every accepted result word against them.
// ----------------------------------------------------------------------------
module gcdlr_ratio_checker #(
	parameter int OPERAND_BITS = gcdlr_pkg::OPERAND_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 operand_valid,
	input  logic                 operand_stall,
	input  gcdlr_pkg::in_word_t  operands,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  gcdlr_pkg::out_word_t result,
	output int                   mismatches,
	output int                   outstanding,
	output int                   checked
);
	import gcdlr_pkg::*;

	out_word_t ratios_due[$];

	// Euclid on the masked operands; a zero operand short-circuits to the other one.
	function automatic out_word_t predict_ratio(in_word_t w);
		bit [63:0] mask;
		bit [63:0] x;
		bit [63:0] y;
		bit [63:0] p;
		bit [63:0] q;
		bit [63:0] r;
		bit [63:0] fi;
		bit [63:0] fd;
		out_word_t e;
		mask = (64'd1 << OPERAND_BITS) - 64'd1;
		x = {32'd0, w.first_value} & mask;
		y = {32'd0, w.second_value} & mask;
		e = '0;
		if (x == 64'd0 || y == 64'd0) begin
			p = (x == 64'd0) ? y : x;
			e.divisor = p[FIELD_BITS-1:0];
			e.zero_operand = 1'b1;
		end else begin
			p = x;
			q = y;
			while (q != 64'd0) begin
				r = p % q;
				p = q;
				q = r;
			end
			fi = y / p;
			fd = x / p;
			e.divisor = p[FIELD_BITS-1:0];
			e.interp_factor = fi[FIELD_BITS-1:0];
			e.decim_factor = fd[FIELD_BITS-1:0];
			e.multiple = fd * y;
		end
		return e;
	endfunction

	function automatic int field_off(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Results are popped before operands are pushed, since a result word can
	// never belong to the operand word taken at the same edge.
	always @(posedge clk) begin : watch
		out_word_t want;
		int bad;
		bad = 0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (ratios_due.size() == 0) begin
					$error("result word %0h arrived with nothing expected", result);
					bad++;
				end else begin
					want = ratios_due.pop_front();
					bad += field_off("divisor", want.divisor, result.divisor);
					bad += field_off("multiple", want.multiple, result.multiple);
					bad += field_off("interp_factor", want.interp_factor,
						result.interp_factor);
					bad += field_off("decim_factor", want.decim_factor,
						result.decim_factor);
					bad += field_off("zero_operand", want.zero_operand,
						result.zero_operand);
				end
				checked <= checked + 1;
			end
			if (operand_valid && !operand_stall)
				ratios_due.push_back(predict_ratio(operands));
		end
		mismatches <= mismatches + bad;
		outstanding <= ratios_due.size();
	end

endmodule

// ----- tb/sv/gcd_lcm_resample_ratio_tb.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_resample_ratio_tb: stimulus and verdict for the ratio block
// Sends corner operand pairs and then random pairs shaped like sample rates,
// shared factors and many trailing zeros, with random idling on both sides. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module gcd_lcm_resample_ratio_tb;
	import gcdlr_pkg::*;

	// With about 28 percent idling on each side, a correct run of some 620
	// words ends well before the cycle limit below.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_WORDS  = 600;
	localparam int DRAIN_CYCLES  = 300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      operand_valid;
	logic      operand_stall;
	in_word_t  operands;
	logic      result_valid;
	logic      result_stall = 1'b1;
	out_word_t result;

	int mismatches;
	int outstanding;
	int checked;
	int cycles;
	int words_sent;
	int zero_words;

	// While calm is set neither side idles, so the block sees words back to
	// back and the result side never stalls.
	bit calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gcd_lcm_resample_ratio dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.operand_valid(operand_valid),
		.operand_stall(operand_stall),
		.operands     (operands),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	gcdlr_ratio_checker ratio_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.operand_valid(operand_valid),
		.operand_stall(operand_stall),
		.operands     (operands),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked)
	);

	// The result side stalls at random, except in the calm stretch.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 28);
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic in_word_t pair(logic [31:0] a, logic [31:0] b);
		in_word_t w;
		w.first_value = a;
		w.second_value = b;
		return w;
	endfunction

	// Random operand pairs. Most are shaped so that the gcd is interesting:
	// audio sample rates, products with a shared factor, or values with many
	// trailing zeros. The rest is noise, zero operands, equal and small pairs.
	function automatic in_word_t make_operand_pair();
		logic [31:0] rates[12] = '{32'd8000, 32'd11025, 32'd16000, 32'd22050,
			32'd32000, 32'd44100, 32'd48000, 32'd88200, 32'd96000, 32'd176400,
			32'd192000, 32'd384000};
		logic [31:0] g;
		logic [31:0] a;
		logic [31:0] b;
		int kind;
		kind = $urandom_range(99);
		if (kind < 30) begin
			a = $urandom();
			b = $urandom();
		end else if (kind < 55) begin
			a = rates[$urandom_range(11)] * $urandom_range(1, 16);
			b = rates[$urandom_range(11)] * $urandom_range(1, 16);
		end else if (kind < 72) begin
			g = $urandom_range(1, 65535);
			a = g * $urandom_range(1, 65535);
			b = g * $urandom_range(1, 65535);
		end else if (kind < 84) begin
			a = $urandom() << $urandom_range(0, 31);
			b = $urandom() << $urandom_range(0, 31);
		end else if (kind < 91) begin
			a = $urandom();
			b = 32'd0;
			if ($urandom_range(1))
				{a, b} = {b, a};
		end else if (kind < 94) begin
			a = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
			b = a;
		end else begin
			a = $urandom_range(0, 15);
			b = $urandom_range(0, 15);
		end
		return pair(a, b);
	endfunction

	// Offers one word and returns at the edge where it is taken. The valid
	// stays high into the next call, which either drops it to idle or
	// presents the next word in the same step.
	task automatic send_word(in_word_t w);
		while (!calm && $urandom_range(99) < 28) begin
			operand_valid <= 1'b0;
			@(posedge clk);
		end
		operand_valid <= 1'b1;
		operands <= w;
		if (w.first_value == 0 || w.second_value == 0)
			zero_words++;
		words_sent++;
		@(posedge clk);
		while (operand_stall)
			@(posedge clk);
	endtask

	// Holds the operand side idle until every predicted result has been
	// read. The first edge lets the count of the last push settle.
	task automatic wait_results();
		operand_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		in_word_t corner_words[$];
		operand_valid <= 1'b0;
		operands <= '0;
		calm = 1'b0;

		// Zero operands on either side and both, unit values, the largest
		// values, coprime and equal pairs, powers of two and common rates.
		corner_words.push_back(pair(32'd0, 32'd0));
		corner_words.push_back(pair(32'd0, 32'hFFFF_FFFF));
		corner_words.push_back(pair(32'hFFFF_FFFF, 32'd0));
		corner_words.push_back(pair(32'd0, 32'd5));
		corner_words.push_back(pair(32'd7, 32'd0));
		corner_words.push_back(pair(32'd1, 32'd1));
		corner_words.push_back(pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		corner_words.push_back(pair(32'hFFFF_FFFF, 32'd1));
		corner_words.push_back(pair(32'd1, 32'hFFFF_FFFF));
		corner_words.push_back(pair(32'hFFFF_FFFF, 32'hFFFF_FFFE));
		corner_words.push_back(pair(32'd4294967291, 32'd4294967279));
		corner_words.push_back(pair(32'h8000_0000, 32'h4000_0000));
		corner_words.push_back(pair(32'h8000_0000, 32'h8000_0000));
		corner_words.push_back(pair(32'h8000_0000, 32'd1));
		corner_words.push_back(pair(32'h8000_0000, 32'hC000_0000));
		corner_words.push_back(pair(32'hAAAA_AAAA, 32'h5555_5555));
		corner_words.push_back(pair(32'd48000, 32'd44100));
		corner_words.push_back(pair(32'd44100, 32'd48000));
		corner_words.push_back(pair(32'd96000, 32'd8000));
		corner_words.push_back(pair(32'd12, 32'd18));
		corner_words.push_back(pair(32'd2971215073, 32'd1836311903));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_words[i])
			send_word(corner_words[i]);
		wait_results();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 150 && i < 270);
			if (i == 400)
				wait_results();
			send_word(make_operand_pair());
		end
		calm = 1'b0;

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operand words (%0d directed, %0d random), %0d with a zero operand.",
			words_sent, corner_words.size(), RANDOM_WORDS, zero_words);
		$display("Checked %0d result words, %0d field mismatches.", checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/gcdlr_pkg.sv
rtl/gcdlr_dp.sv
rtl/gcdlr_ctrl.sv
rtl/gcd_lcm_resample_ratio.sv
tb/sv/gcdlr_ratio_checker.sv
tb/sv/gcd_lcm_resample_ratio_tb.sv
